// ----- rtl/irb_pkg.sv -----
`timescale 1ns / 1ps
package irb_pkg;

    // pixel word width and trig fraction width are fixed by the payload format
    localparam int PIXEL_BITS = 16;
    localparam int TRIG_FRAC  = 14;

    // rotation mode codes
    localparam logic [2:0] MODE_LEFT   = 3'd0;
    localparam logic [2:0] MODE_RIGHT  = 3'd1;
    localparam logic [2:0] MODE_UPDOWN = 3'd2;
    localparam logic [2:0] MODE_FLIP_V = 3'd3;
    localparam logic [2:0] MODE_FLIP_H = 3'd4;
    localparam logic [2:0] MODE_ARB    = 3'd5;

    // register indexes on the configuration port
    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_IN_WIDTH   = 3'd1;
    localparam logic [2:0] REG_IN_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_COS        = 3'd3;
    localparam logic [2:0] REG_SIN        = 3'd4;
    localparam logic [2:0] REG_OUT_WIDTH  = 3'd5;
    localparam logic [2:0] REG_OUT_HEIGHT = 3'd6;

    // transaction opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [8:0]            col;
        logic [8:0]            row;
        logic [PIXEL_BITS-1:0] pixel_in;
    } src_item_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_out;
        logic                  outside;
    } res_item_t;

endpackage

// ----- rtl/image_rotate_bilinear.sv -----
`timescale 1ns / 1ps
// Frame-store image rotator. Write transactions (op 0) load one source pixel at (col, row);
// read transactions (op 1) return one result for the output position (col, row) under the
// programmed mode: rotate left, rotate right, upside down, flip vertical, flip horizontal,
// or rotation by an arbitrary angle about the centre with bilinear interpolation (cos and
// sin in signed Q2.14). Sources off the image, or off its interior in arbitrary mode, give
// pixel 0 with outside set. The block takes one transaction per clock unless res_ready
// holds the pipeline; a read result passes through six register stages: offsets, four
// small products, source index and fraction, frame store read, horizontal blend,
// vertical blend and rounding. The frame store is split into four single-port banks by
// column and row parity, so the four neighbours of any position are read in the same cycle;
// writes go through the same memory stage, which keeps reads and writes in order. The
// store has no reset: read only positions that were written. Configure only while idle.
module image_rotate_bilinear
    import irb_pkg::*;
#(
    parameter int MAX_COLS  = 256,
    parameter int MAX_ROWS  = 256,
    parameter int FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    // source transactions
    input  logic        src_valid,
    output logic        src_ready,
    input  src_item_t   src_item,
    // result transactions
    output logic        res_valid,
    input  logic        res_ready,
    output res_item_t   res_item,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);
    // signed source index width: floor of the rotated coordinate plus half the size
    localparam int DW = (CW > RW) ? CW : RW;
    localparam int IW = ((DW + 1 > 14) ? DW + 1 : 14) + 1;
    localparam int HC = (MAX_COLS + 1) / 2;
    localparam int HR = (MAX_ROWS + 1) / 2;
    localparam int BANK_DEPTH = HC * HR;
    localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int TW = PIXEL_BITS + FRAC_BITS;
    localparam int XW = PIXEL_BITS + 2 * FRAC_BITS;
    localparam logic [FRAC_BITS:0] W_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [XW-1:0] ROUND_HALF = XW'(1) << (2 * FRAC_BITS - 1);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [2:0]         rotation_mode_reg;
    logic [8:0]         in_width_reg;
    logic [8:0]         in_height_reg;
    logic signed [15:0] cos_q_reg;
    logic signed [15:0] sin_q_reg;
    logic [9:0]         out_width_reg;
    logic [9:0]         out_height_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_mode_reg <= MODE_LEFT;
            in_width_reg      <= 9'd256;
            in_height_reg     <= 9'd256;
            cos_q_reg         <= 16'sd16384;
            sin_q_reg         <= 16'sd0;
            out_width_reg     <= 10'd256;
            out_height_reg    <= 10'd256;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_MODE:       rotation_mode_reg <= pwdata[2:0];
                REG_IN_WIDTH:   in_width_reg      <= pwdata[8:0];
                REG_IN_HEIGHT:  in_height_reg     <= pwdata[8:0];
                REG_COS:        cos_q_reg         <= pwdata[15:0];
                REG_SIN:        sin_q_reg         <= pwdata[15:0];
                REG_OUT_WIDTH:  out_width_reg     <= pwdata[9:0];
                REG_OUT_HEIGHT: out_height_reg    <= pwdata[9:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_MODE:       prdata = {29'd0, rotation_mode_reg};
            REG_IN_WIDTH:   prdata = {23'd0, in_width_reg};
            REG_IN_HEIGHT:  prdata = {23'd0, in_height_reg};
            REG_COS:        prdata = {16'd0, cos_q_reg};
            REG_SIN:        prdata = {16'd0, sin_q_reg};
            REG_OUT_WIDTH:  prdata = {22'd0, out_width_reg};
            REG_OUT_HEIGHT: prdata = {22'd0, out_height_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // source size saturated to 1..MAX
    logic [CW-1:0] nx;
    logic [RW-1:0] ny;
    logic [IW-1:0] nx_w;
    logic [IW-1:0] ny_w;

    always_comb
    begin
        if (in_width_reg == 9'd0)
            nx = CW'(1);
        else if (32'(in_width_reg) > MAX_COLS)
            nx = CW'(MAX_COLS);
        else
            nx = CW'(in_width_reg);
        if (in_height_reg == 9'd0)
            ny = RW'(1);
        else if (32'(in_height_reg) > MAX_ROWS)
            ny = RW'(MAX_ROWS);
        else
            ny = RW'(in_height_reg);
    end

    assign nx_w = IW'(nx);
    assign ny_w = IW'(ny);

    // ---------------------------------------------------------------
    // stage advance: a stage loads when it is empty or moves on
    // ---------------------------------------------------------------
    logic [6:1] rdy;
    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic       s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic       s4_op_reg, s4_ok_reg, s4_ip_reg, s4_jp_reg;

    assign rdy[6]    = !s6_valid_reg || res_ready;
    assign rdy[5]    = !s5_valid_reg || rdy[6];
    assign rdy[4]    = !s4_valid_reg || rdy[5];
    assign rdy[3]    = !s3_valid_reg || rdy[4];
    assign rdy[2]    = !s2_valid_reg || rdy[3];
    assign rdy[1]    = !s1_valid_reg || rdy[2];
    assign src_ready = rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy[1]) s1_valid_reg <= src_valid;
            if (rdy[2]) s2_valid_reg <= s1_valid_reg;
            if (rdy[3]) s3_valid_reg <= s2_valid_reg;
            if (rdy[4]) s4_valid_reg <= s3_valid_reg;
            // write transactions end at the memory stage
            if (rdy[5]) s5_valid_reg <= s4_valid_reg && (s4_op_reg == OP_READ);
            if (rdy[6]) s6_valid_reg <= s5_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: exact re-indexing and centred offsets
    // ---------------------------------------------------------------
    logic                  s1_op_reg, s1_ok_reg, s1_wr_ok_reg;
    logic [IW-1:0]         s1_i_reg, s1_j_reg;
    logic signed [10:0]    s1_xo_reg, s1_yo_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic                  s1_ok_next;
    logic [IW-1:0]         s1_i_next, s1_j_next;
    logic [IW-1:0]         col_w, row_w;

    assign col_w = IW'(src_item.col);
    assign row_w = IW'(src_item.row);

    always_comb
    begin
        s1_ok_next = 1'b0;
        s1_i_next  = col_w;
        s1_j_next  = row_w;
        if (src_item.op == OP_READ)
        begin
            unique case (rotation_mode_reg)
                MODE_LEFT:
                begin
                    s1_ok_next = (row_w < nx_w) && (col_w < ny_w);
                    s1_i_next  = nx_w - IW'(1) - row_w;
                    s1_j_next  = col_w;
                end
                MODE_RIGHT:
                begin
                    s1_ok_next = (row_w < nx_w) && (col_w < ny_w);
                    s1_i_next  = row_w;
                    s1_j_next  = ny_w - IW'(1) - col_w;
                end
                MODE_UPDOWN:
                begin
                    s1_ok_next = (col_w < nx_w) && (row_w < ny_w);
                    s1_i_next  = nx_w - IW'(1) - col_w;
                    s1_j_next  = ny_w - IW'(1) - row_w;
                end
                MODE_FLIP_V:
                begin
                    s1_ok_next = (col_w < nx_w) && (row_w < ny_w);
                    s1_j_next  = ny_w - IW'(1) - row_w;
                end
                MODE_FLIP_H:
                begin
                    s1_ok_next = (col_w < nx_w) && (row_w < ny_w);
                    s1_i_next  = nx_w - IW'(1) - col_w;
                end
                default:
                    s1_ok_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s1_op_reg    <= src_item.op;
            s1_ok_reg    <= s1_ok_next;
            s1_wr_ok_reg <= (32'(src_item.col) < MAX_COLS) && (32'(src_item.row) < MAX_ROWS);
            s1_i_reg     <= s1_i_next;
            s1_j_reg     <= s1_j_next;
            s1_xo_reg    <= $signed({2'b00, src_item.col}) - $signed({2'b00, out_width_reg[9:1]});
            s1_yo_reg    <= $signed({2'b00, src_item.row}) - $signed({2'b00, out_height_reg[9:1]});
            s1_pix_reg   <= src_item.pixel_in;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: the four rotation products
    // ---------------------------------------------------------------
    logic                  s2_op_reg, s2_ok_reg, s2_wr_ok_reg;
    logic [IW-1:0]         s2_i_reg, s2_j_reg;
    logic signed [26:0]    s2_xc_reg, s2_ys_reg, s2_yc_reg, s2_xs_reg;
    logic [PIXEL_BITS-1:0] s2_pix_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            s2_op_reg    <= s1_op_reg;
            s2_ok_reg    <= s1_ok_reg;
            s2_wr_ok_reg <= s1_wr_ok_reg;
            s2_i_reg     <= s1_i_reg;
            s2_j_reg     <= s1_j_reg;
            s2_xc_reg    <= s1_xo_reg * cos_q_reg;
            s2_ys_reg    <= s1_yo_reg * sin_q_reg;
            s2_yc_reg    <= s1_yo_reg * cos_q_reg;
            s2_xs_reg    <= s1_xo_reg * sin_q_reg;
            s2_pix_reg   <= s1_pix_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: source index, interior check and fractions
    // ---------------------------------------------------------------
    logic signed [27:0]          x_q, y_q;
    logic [IW-1:0]               i_arb, j_arb;
    logic                        ok_arb;
    logic [TRIG_FRAC+FRAC_BITS-1:0] fx_wide, fy_wide;
    logic [FRAC_BITS-1:0]        fx_arb, fy_arb;
    logic                        use_arb;

    assign x_q = {s2_xc_reg[26], s2_xc_reg} + {s2_ys_reg[26], s2_ys_reg};
    assign y_q = {s2_yc_reg[26], s2_yc_reg} - {s2_xs_reg[26], s2_xs_reg};

    // floor is the arithmetic shift of the Q.14 value
    assign i_arb = {{(IW-14){x_q[27]}}, x_q[27:14]} + IW'(nx >> 1);
    assign j_arb = {{(IW-14){y_q[27]}}, y_q[27:14]} + IW'(ny >> 1);
    assign ok_arb = !i_arb[IW-1] && (i_arb < nx_w - IW'(1))
                 && !j_arb[IW-1] && (j_arb < ny_w - IW'(1));

    // rescale the 14 fraction bits to FRAC_BITS
    assign fx_wide = {x_q[13:0], {FRAC_BITS{1'b0}}} >> TRIG_FRAC;
    assign fy_wide = {y_q[13:0], {FRAC_BITS{1'b0}}} >> TRIG_FRAC;
    assign fx_arb  = fx_wide[FRAC_BITS-1:0];
    assign fy_arb  = fy_wide[FRAC_BITS-1:0];
    assign use_arb = (s2_op_reg == OP_READ) && (rotation_mode_reg == MODE_ARB);

    logic                  s3_op_reg, s3_ok_reg, s3_wr_ok_reg;
    logic [IW-1:0]         s3_i_reg, s3_j_reg;
    logic [FRAC_BITS-1:0]  s3_fx_reg, s3_fy_reg;
    logic [FRAC_BITS:0]    s3_wfx_reg, s3_wfy_reg;
    logic [PIXEL_BITS-1:0] s3_pix_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            s3_op_reg    <= s2_op_reg;
            s3_wr_ok_reg <= s2_wr_ok_reg;
            s3_pix_reg   <= s2_pix_reg;
            s3_ok_reg    <= use_arb ? ok_arb : s2_ok_reg;
            s3_i_reg     <= use_arb ? i_arb : s2_i_reg;
            s3_j_reg     <= use_arb ? j_arb : s2_j_reg;
            s3_fx_reg    <= fx_arb;
            s3_fy_reg    <= fy_arb;
            s3_wfx_reg   <= W_ONE - {1'b0, fx_arb};
            s3_wfy_reg   <= W_ONE - {1'b0, fy_arb};
        end
    end

    // ---------------------------------------------------------------
    // stage 4: parity-banked frame store, one port per bank
    // ---------------------------------------------------------------
    logic [PIXEL_BITS-1:0] bank_mem [4][BANK_DEPTH];
    logic [PIXEL_BITS-1:0] bank_q_reg [4];
    logic [AW-1:0]         bank_addr [4];
    logic [3:0]            bank_we;

    always_comb
    begin
        logic [IW-1:0] ch;
        logic [IW-1:0] rh;
        logic          pc;
        logic          pr;
        for (int b = 0; b < 4; b++)
        begin
            pc = b[0];
            pr = b[1];
            // neighbour i+1 lands in the other column bank, one slot up when i is odd
            ch = (s3_i_reg >> 1) + IW'(s3_i_reg[0] & !pc);
            rh = (s3_j_reg >> 1) + IW'(s3_j_reg[0] & !pr);
            bank_addr[b] = AW'(rh * HC + ch);
            bank_we[b]   = s3_valid_reg && (s3_op_reg == OP_WRITE) && s3_wr_ok_reg
                        && (s3_i_reg[0] == pc) && (s3_j_reg[0] == pr);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (rdy[4])
            begin
                if (bank_we[b])
                    bank_mem[b][bank_addr[b]] <= s3_pix_reg;
                bank_q_reg[b] <= bank_mem[b][bank_addr[b]];
            end
        end
    end

    logic [FRAC_BITS-1:0] s4_fx_reg, s4_fy_reg;
    logic [FRAC_BITS:0]   s4_wfx_reg, s4_wfy_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            s4_op_reg  <= s3_op_reg;
            s4_ok_reg  <= s3_ok_reg;
            s4_ip_reg  <= s3_i_reg[0];
            s4_jp_reg  <= s3_j_reg[0];
            s4_fx_reg  <= s3_fx_reg;
            s4_fy_reg  <= s3_fy_reg;
            s4_wfx_reg <= s3_wfx_reg;
            s4_wfy_reg <= s3_wfy_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 5: undo the bank swap, blend along x
    // ---------------------------------------------------------------
    logic [PIXEL_BITS-1:0] c00, c10, c01, c11;

    assign c00 = bank_q_reg[{s4_jp_reg,  s4_ip_reg}];
    assign c10 = bank_q_reg[{s4_jp_reg, !s4_ip_reg}];
    assign c01 = bank_q_reg[{!s4_jp_reg,  s4_ip_reg}];
    assign c11 = bank_q_reg[{!s4_jp_reg, !s4_ip_reg}];

    logic                  s5_ok_reg;
    logic [PIXEL_BITS-1:0] s5_c00_reg;
    logic [TW-1:0]         s5_top_reg, s5_bot_reg;
    logic [FRAC_BITS-1:0]  s5_fy_reg;
    logic [FRAC_BITS:0]    s5_wfy_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            s5_ok_reg  <= s4_ok_reg;
            s5_c00_reg <= c00;
            s5_top_reg <= TW'(c00) * TW'(s4_wfx_reg) + TW'(c10) * TW'(s4_fx_reg);
            s5_bot_reg <= TW'(c01) * TW'(s4_wfx_reg) + TW'(c11) * TW'(s4_fx_reg);
            s5_fy_reg  <= s4_fy_reg;
            s5_wfy_reg <= s4_wfy_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 6: blend along y, round half up, output register
    // ---------------------------------------------------------------
    logic [XW-1:0]         acc;
    logic [PIXEL_BITS-1:0] pix_sel;

    assign acc = XW'(s5_top_reg) * XW'(s5_wfy_reg) + XW'(s5_bot_reg) * XW'(s5_fy_reg)
               + ROUND_HALF;

    always_comb
    begin
        if (!s5_ok_reg)
            pix_sel = '0;
        else if (rotation_mode_reg == MODE_ARB)
            pix_sel = acc[2*FRAC_BITS +: PIXEL_BITS];
        else
            pix_sel = s5_c00_reg;
    end

    logic [PIXEL_BITS-1:0] s6_pix_reg;
    logic                  s6_outside_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            s6_pix_reg     <= pix_sel;
            s6_outside_reg <= !s5_ok_reg;
        end
    end

    assign res_valid          = s6_valid_reg;
    assign res_item.pixel_out = s6_pix_reg;
    assign res_item.outside   = s6_outside_reg;

`ifndef SYNTHESIS
    // input is held off only when every stage is occupied
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !src_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                        && s4_valid_reg && s5_valid_reg && s6_valid_reg))
        else $error("input stalled with a bubble in the pipeline");

    // a write transaction never reaches the blend stages
    a_write_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (rdy[5] && s4_valid_reg && (s4_op_reg == OP_WRITE)) |=> !s5_valid_reg)
        else $error("write transaction produced a result");

    // exact modes only address inside the source image
    a_exact_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && (s3_op_reg == OP_READ) && s3_ok_reg
         && (rotation_mode_reg != MODE_ARB)) |-> ((s3_i_reg < nx_w) && (s3_j_reg < ny_w)))
        else $error("source index off the image");

    // unused modes always report outside
    a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_item.outside) |-> (rotation_mode_reg <= MODE_ARB))
        else $error("valid pixel under an unused mode");
`endif

endmodule

// ----- tb/image_rotate_bilinear_tb.sv -----
`timescale 1ns / 1ps
module image_rotate_bilinear_tb;
    import irb_pkg::*;

    localparam int STORE_COLS = 256;
    localparam int STORE_ROWS = 256;
    localparam int DRAIN_CYCLES = 16;
    localparam int NUM_PHASES = 30;
    localparam int ITEMS_PER_PHASE = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        src_valid = 1'b0;
    logic        src_ready;
    src_item_t   src_item = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_item_t   res_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    image_rotate_bilinear DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // shadow copy of the configuration registers
    logic [2:0]  cfg_mode = MODE_LEFT;
    logic [8:0]  cfg_in_w = 9'd256;
    logic [8:0]  cfg_in_h = 9'd256;
    logic [15:0] cfg_cos = 16'd16384;
    logic [15:0] cfg_sin = 16'd0;
    logic [9:0]  cfg_out_w = 10'd256;
    logic [9:0]  cfg_out_h = 10'd256;

    // predictor image, updated on accepted write transactions
    logic [PIXEL_BITS-1:0] image_mem [STORE_COLS*STORE_ROWS];
    // generator view of which store entries have been written
    bit written_map [STORE_COLS*STORE_ROWS];

    // store entries touched by the last call of rotate_pixel
    int touched_col [4];
    int touched_row [4];
    int touched_n;

    src_item_t pending_items [$];
    res_item_t expected_results [$];
    int  err_count = 0;
    int  src_idle = 0;
    int  res_idle = 0;
    bit  src_hold = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int clamp_dim(int v, int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // expected result of a read at output position (col, row)
    function automatic res_item_t rotate_pixel(int col, int row);
        res_item_t r;
        int nx, ny, sc, sr;
        bit ok;
        longint c, s, xo, yo, x, y, ii, jj, fx, fy, top, bot, acc;
        longint one;
        nx = clamp_dim(cfg_in_w, STORE_COLS);
        ny = clamp_dim(cfg_in_h, STORE_ROWS);
        ok = 1'b0;
        sc = 0;
        sr = 0;
        touched_n = 0;
        r = '0;
        case (cfg_mode)
            MODE_LEFT:
            begin
                ok = row < nx && col < ny;
                sc = nx - 1 - row;
                sr = col;
            end
            MODE_RIGHT:
            begin
                ok = row < nx && col < ny;
                sc = row;
                sr = ny - 1 - col;
            end
            MODE_UPDOWN:
            begin
                ok = col < nx && row < ny;
                sc = nx - 1 - col;
                sr = ny - 1 - row;
            end
            MODE_FLIP_V:
            begin
                ok = col < nx && row < ny;
                sc = col;
                sr = ny - 1 - row;
            end
            MODE_FLIP_H:
            begin
                ok = col < nx && row < ny;
                sc = nx - 1 - col;
                sr = row;
            end
            MODE_ARB:
            begin
                c = longint'($signed(cfg_cos));
                s = longint'($signed(cfg_sin));
                xo = longint'(col) - longint'(cfg_out_w / 2);
                yo = longint'(row) - longint'(cfg_out_h / 2);
                x = xo * c + yo * s;
                y = yo * c - xo * s;
                // floor of the shifted coordinate, fraction from the low bits
                ii = (x >>> TRIG_FRAC) + nx / 2;
                jj = (y >>> TRIG_FRAC) + ny / 2;
                fx = x & ((64'sd1 <<< TRIG_FRAC) - 1);
                fy = y & ((64'sd1 <<< TRIG_FRAC) - 1);
                one = 64'sd1 <<< TRIG_FRAC;
                if (ii >= 0 && ii < nx - 1 && jj >= 0 && jj < ny - 1)
                begin
                    ok = 1'b1;
                    sc = int'(ii);
                    sr = int'(jj);
                    touched_col = '{sc, sc + 1, sc, sc + 1};
                    touched_row = '{sr, sr, sr + 1, sr + 1};
                    touched_n = 4;
                    top = longint'(image_mem[sr*STORE_COLS + sc]) * (one - fx)
                        + longint'(image_mem[sr*STORE_COLS + sc + 1]) * fx;
                    bot = longint'(image_mem[(sr+1)*STORE_COLS + sc]) * (one - fx)
                        + longint'(image_mem[(sr+1)*STORE_COLS + sc + 1]) * fx;
                    acc = top * (one - fy) + bot * fy + (64'sd1 <<< (2*TRIG_FRAC - 1));
                    r.pixel_out = PIXEL_BITS'(acc >>> (2*TRIG_FRAC));
                end
            end
            default:
                ok = 1'b0;
        endcase
        if (ok && cfg_mode != MODE_ARB)
        begin
            touched_col[0] = sc;
            touched_row[0] = sr;
            touched_n = 1;
            r.pixel_out = image_mem[sr*STORE_COLS + sc];
        end
        if (!ok)
            r.pixel_out = '0;
        r.outside = !ok;
        return r;
    endfunction

    // driver: offers pending transactions, updates the predictor on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
        end
        else
        begin
            if (src_valid && src_ready)
            begin
                if (src_item.op == OP_WRITE)
                begin
                    if (src_item.col < STORE_COLS && src_item.row < STORE_ROWS)
                        image_mem[src_item.row*STORE_COLS + src_item.col] = src_item.pixel_in;
                end
                else
                begin
                    expected_results.push_back(rotate_pixel(src_item.col, src_item.row));
                end
            end
            if (!src_valid || src_ready)
            begin
                if (pending_items.size() > 0 && !src_hold && $urandom_range(99) >= src_idle)
                begin
                    src_valid <= 1'b1;
                    src_item <= pending_items.pop_front();
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transaction against the oldest prediction
    always @(posedge clk)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%t unexpected result: expected none actual %h/%b",
                             $realtime, res_item.pixel_out, res_item.outside);
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.pixel_out !== res_item.pixel_out)
                    begin
                        $display("%t pixel_out mismatch: expected %h actual %h",
                                 $realtime, want.pixel_out, res_item.pixel_out);
                        err_count++;
                    end
                    if (want.outside !== res_item.outside)
                    begin
                        $display("%t outside mismatch: expected %b actual %b",
                                 $realtime, want.outside, res_item.outside);
                        err_count++;
                    end
                end
            end
            res_ready <= ($urandom_range(99) >= res_idle);
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODE:       cfg_mode = value[2:0];
            REG_IN_WIDTH:   cfg_in_w = value[8:0];
            REG_IN_HEIGHT:  cfg_in_h = value[8:0];
            REG_COS:        cfg_cos = value[15:0];
            REG_SIN:        cfg_sin = value[15:0];
            REG_OUT_WIDTH:  cfg_out_w = value[9:0];
            REG_OUT_HEIGHT: cfg_out_h = value[9:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || src_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_write(int col, int row, logic [15:0] pix);
        src_item_t it;
        it.op = OP_WRITE;
        it.col = col[8:0];
        it.row = row[8:0];
        it.pixel_in = pix;
        if (col < STORE_COLS && row < STORE_ROWS)
            written_map[row*STORE_COLS + col] = 1'b1;
        pending_items.push_back(it);
    endtask

    // queues a read, loading any store entry it touches that was never written
    task automatic push_read(int col, int row);
        src_item_t it;
        res_item_t unused;
        int k;
        unused = rotate_pixel(col, row);
        for (k = 0; k < touched_n; k++)
        begin
            if (!written_map[touched_row[k]*STORE_COLS + touched_col[k]])
                push_write(touched_col[k], touched_row[k], 16'($urandom));
        end
        it.op = OP_READ;
        it.col = col[8:0];
        it.row = row[8:0];
        it.pixel_in = 16'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic run_phase(int p);
        int mode, in_w, in_h, out_w, out_h, cos_v, sin_v, nx, ny, span, n, pick;
        real ang;
        mode = (p < 24) ? p % 8 : MODE_ARB;
        in_w = $urandom_range(1, 12);
        in_h = $urandom_range(1, 12);
        out_w = $urandom_range(1, 16);
        out_h = $urandom_range(1, 16);
        ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
        cos_v = $rtoi($cos(ang) * 16384.0);
        sin_v = $rtoi($sin(ang) * 16384.0);
        // extremes of sizes and of the trig values
        case (p)
            3, 10:
            begin
                in_w = 256;
                in_h = 256;
            end
            5:
            begin
                in_w = 0;
                in_h = 511;
                cos_v = 16384;
                sin_v = -16384;
                out_w = 0;
                out_h = 0;
            end
            13:
            begin
                in_w = 256;
                in_h = 256;
                cos_v = -16384;
                sin_v = 16384;
                out_w = 512;
                out_h = 512;
            end
            20:
            begin
                in_w = 300;
                in_h = 0;
            end
            default: ;
        endcase
        cfg_write(REG_MODE, mode);
        cfg_write(REG_IN_WIDTH, in_w);
        cfg_write(REG_IN_HEIGHT, in_h);
        cfg_write(REG_COS, cos_v & 32'hFFFF);
        cfg_write(REG_SIN, sin_v & 32'hFFFF);
        cfg_write(REG_OUT_WIDTH, out_w);
        cfg_write(REG_OUT_HEIGHT, out_h);

        // idling schedule over the run
        if (p < 10)
        begin
            src_idle = 21;
            res_idle = 68;
        end
        else if (p < 20)
        begin
            src_idle = 68;
            res_idle = 21;
        end
        else
        begin
            src_idle = 0;
            res_idle = 0;
        end

        nx = clamp_dim(cfg_in_w, STORE_COLS);
        ny = clamp_dim(cfg_in_h, STORE_ROWS);
        span = (mode == MODE_ARB) ? clamp_dim(out_w, 512) : ((nx > ny) ? nx : ny) + 1;

        // directed corners and the ignored out-of-range write
        if (p < 8)
        begin
            push_read(0, 0);
            push_write(511, 511, 16'hFFFF);
            push_read(511, 511);
        end

        for (n = 0; n < ITEMS_PER_PHASE; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                push_write($urandom_range(nx - 1), $urandom_range(ny - 1), 16'($urandom));
            else if (pick < 25)
                push_write($urandom_range(511), $urandom_range(511),
                           ($urandom_range(1)) ? 16'hFFFF : 16'($urandom));
            else if (pick < 85)
                push_read($urandom_range(span - 1),
                          $urandom_range(((mode == MODE_ARB) ? clamp_dim(out_h, 512) : span) - 1));
            else
                push_read($urandom_range(511), $urandom_range(511));
        end

        // hold the sender once until every outstanding result has drained
        if (p == 7)
        begin
            while (pending_items.size() > ITEMS_PER_PHASE / 2)
                @(posedge clk);
            src_hold = 1'b1;
            while (src_valid || expected_results.size() > 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
            src_hold = 1'b0;
        end
        wait_idle();
    endtask

    initial begin
        int p;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (p = 0; p < NUM_PHASES; p++)
            run_phase(p);
        wait_idle();
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/irb_pkg.sv
rtl/image_rotate_bilinear.sv
tb/image_rotate_bilinear_tb.sv
